// ===== rtl/open_address_hash_map_unit_macros.svh =====
// ----------------------------------------------------------------------------
// open address hash map unit assertion macros
// shared property templates for the hash map assertions
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESS_HASH_MAP_UNIT_MACROS_SVH
`define OPEN_ADDRESS_HASH_MAP_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define OAHM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define OAHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/oahm_pkg.sv =====
// ----------------------------------------------------------------------------
// oahm_pkg
// constants and codes for the open address hash map unit
// ----------------------------------------------------------------------------
package oahm_pkg;

    // parameter defaults
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int PROBE_SHIFT_DEF = 5;
    localparam int KEY_BITS_DEF    = 32;

    // size register
    localparam int SIZE_LOG2_W     = 4;
    localparam int SIZE_LOG2_RESET = 10;
    localparam int SIZE_LOG2_MIN   = 3;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 11;
    localparam int IN_W     = 96;
    localparam int OUT_W    = 48;

    // extra probes allowed beyond the slot count
    localparam int PROBE_EXTRA = 33;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // slot marks
    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

endpackage

// ===== rtl/open_address_hash_map_unit.sv =====
// ----------------------------------------------------------------------------
// open_address_hash_map_unit
// key/value table with open addressing and perturbed probing
// ----------------------------------------------------------------------------
// One request in, one result out. The first probe lands at key_hash AND mask,
// later probes at i = 5i + perturb + 1 with perturb starting at the hash and
// shifted right by PROBE_SHIFT per probe. A request passes an accept state,
// then a memory read state and a compare state for each probed slot, then a
// state that writes back and posts the result once the output register is
// free; at most slots + 33 slots are probed. After reset the block sweeps the
// mark memory to empty, one entry per cycle over all TABLE_DEPTH entries, and
// takes no request until the sweep is done; size writes are taken at any time
// but must only be issued while the block is idle. A finished result waits in
// the output register while the next request is already being accepted.
// Deleted slots become tombstones; a set reuses the first tombstone it passed,
// and a set that would fill a never-used slot while fill * 3 >= slots * 2 is
// refused as full.
// ----------------------------------------------------------------------------
`include "open_address_hash_map_unit_macros.svh"

module open_address_hash_map_unit #(
    parameter int TABLE_DEPTH = oahm_pkg::TABLE_DEPTH_DEF,
    parameter int PROBE_SHIFT = oahm_pkg::PROBE_SHIFT_DEF,
    parameter int KEY_BITS    = oahm_pkg::KEY_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // size register write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [oahm_pkg::SIZE_LOG2_W-1:0]  i_cfg_data,
    // request stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [oahm_pkg::IN_W-1:0]         i_s_axis_tdata,  // key, key_hash, value
    input  logic [oahm_pkg::CMD_W-1:0]        i_s_axis_tuser,  // cmd
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [oahm_pkg::OUT_W-1:0]        o_m_axis_tdata   // found, value_out, status,
                                                                // used_count, load_high
);

    // address, count and key widths
    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int L_MAX  = ($clog2(TABLE_DEPTH + 1) - 1 > 16) ? 16
                          : $clog2(TABLE_DEPTH + 1) - 1;
    localparam int LGW    = $clog2(L_MAX + 1);
    localparam int LG_RST = (oahm_pkg::SIZE_LOG2_RESET > L_MAX) ? L_MAX
                          : oahm_pkg::SIZE_LOG2_RESET;
    localparam int CW     = $clog2(TABLE_DEPTH + oahm_pkg::PROBE_EXTRA + 1);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int FW     = CNT_W + 2;
    localparam int KS     = (KEY_BITS < oahm_pkg::WORD_W) ? KEY_BITS : oahm_pkg::WORD_W;
    localparam int WW     = oahm_pkg::WORD_W;
    localparam int DW     = KS + 2 * WW;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_RD   = 5'b00100,
        S_EV   = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    // control state
    t_state                        r_state, n_state;
    logic [AW-1:0]                 r_clr_idx, n_clr_idx;
    logic [LGW-1:0]                r_lg, n_lg;
    logic [CNT_W-1:0]              r_live, n_live;
    logic [CNT_W-1:0]              r_fill, n_fill;
    logic                          r_out_valid, n_out_valid;

    // request and probe registers
    logic [oahm_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [KS-1:0]                 r_key, n_key;
    logic [WW-1:0]                 r_hash, n_hash;
    logic [WW-1:0]                 r_val, n_val;
    logic [AW-1:0]                 r_idx, n_idx;
    logic [WW-1:0]                 r_perturb, n_perturb;
    logic [CW-1:0]                 r_n, n_n;
    logic                          r_hit, n_hit;
    logic                          r_have_empty, n_have_empty;
    logic                          r_have_tomb, n_have_tomb;
    logic [AW-1:0]                 r_tomb_idx, n_tomb_idx;
    logic [WW-1:0]                 r_hit_val, n_hit_val;
    logic [oahm_pkg::OUT_W-1:0]    r_out_data, n_out_data;

    // memory ports
    logic                          w_mark_we;
    logic [AW-1:0]                 w_mark_waddr;
    logic [1:0]                    w_mark_wdata;
    logic [1:0]                    w_mark_q;
    logic                          w_data_we;
    logic [AW-1:0]                 w_data_waddr;
    logic [DW-1:0]                 w_data_wdata;
    logic [DW-1:0]                 w_data_q;

    // derived size terms
    logic [LGW-1:0]                w_cfg_lg;
    logic [AW:0]                   w_slots;
    logic [AW:0]                   w_slots_m1;
    logic [AW-1:0]                 w_mask;
    logic [CW-1:0]                 w_limit_m1;
    logic [FW-1:0]                 w_slots2;
    logic [FW-1:0]                 w_fill3;
    logic [FW-1:0]                 w_fill3_next;
    logic                          w_room;
    logic [AW-1:0]                 w_step_idx;
    logic                          w_key_eq;
    logic                          w_hash_eq;
    logic                          w_out_free;
    logic                          w_fin_go;
    logic [oahm_pkg::STATUS_W-1:0] w_status;
    logic [WW-1:0]                 w_vout;
    logic [CNT_W+oahm_pkg::USED_W-1:0] w_used_ext;

    // slot marks: empty, live or tombstone, swept to empty after reset
    oahm_ram #(
        .WIDTH (2),
        .DEPTH (TABLE_DEPTH)
    ) u_mark_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mark_we),
        .i_wr_addr (w_mark_waddr),
        .i_wr_data (w_mark_wdata),
        .i_rd_addr (r_idx),
        .o_rd_data (w_mark_q)
    );

    // slot payload: value, hash, key from the top bit down
    oahm_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_data_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_data_we),
        .i_wr_addr (w_data_waddr),
        .i_wr_data (w_data_wdata),
        .i_rd_addr (r_idx),
        .o_rd_data (w_data_q)
    );

    // size register write clamps into the usable range
    always_comb begin
        if (int'(i_cfg_data) < oahm_pkg::SIZE_LOG2_MIN) begin
            w_cfg_lg = LGW'(oahm_pkg::SIZE_LOG2_MIN);
        end else if (int'(i_cfg_data) > L_MAX) begin
            w_cfg_lg = LGW'(L_MAX);
        end else begin
            w_cfg_lg = LGW'(i_cfg_data);
        end
    end

    // slot count, mask and probe limit follow the size register
    assign w_slots    = (AW + 1)'(1) << r_lg;
    assign w_slots_m1 = w_slots - (AW + 1)'(1);
    assign w_mask     = w_slots_m1[AW-1:0];
    assign w_limit_m1 = CW'(w_slots) + CW'(oahm_pkg::PROBE_EXTRA - 1);

    // load check: fill * 3 against slots * 2
    assign w_slots2     = FW'({w_slots, 1'b0});
    assign w_fill3      = {2'b00, r_fill} + {1'b0, r_fill, 1'b0};
    assign w_fill3_next = {2'b00, n_fill} + {1'b0, n_fill, 1'b0};
    assign w_room       = w_fill3 < w_slots2;

    // next probe index: 5i + perturb + 1 under the mask
    assign w_step_idx = (r_idx + {r_idx[AW-3:0], 2'b00} + r_perturb[AW-1:0] + AW'(1))
                      & w_mask;

    // slot compare on the word read for the current probe
    assign w_key_eq  = w_data_q[KS-1:0] == r_key;
    assign w_hash_eq = w_data_q[KS+WW-1:KS] == r_hash;

    // result register takes a new result when empty or being drained
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_fin_go   = (r_state == S_FIN) && w_out_free;

    // write data is always the request's own key, hash and value
    assign w_data_wdata = {r_val, r_hash, r_key};

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_lg         = r_lg;
        n_live       = r_live;
        n_fill       = r_fill;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_hash       = r_hash;
        n_val        = r_val;
        n_idx        = r_idx;
        n_perturb    = r_perturb;
        n_n          = r_n;
        n_hit        = r_hit;
        n_have_empty = r_have_empty;
        n_have_tomb  = r_have_tomb;
        n_tomb_idx   = r_tomb_idx;
        n_hit_val    = r_hit_val;
        n_out_data   = r_out_data;
        w_mark_we    = 1'b0;
        w_mark_waddr = r_clr_idx;
        w_mark_wdata = oahm_pkg::MARK_EMPTY;
        w_data_we    = 1'b0;
        w_data_waddr = r_idx;
        w_status     = oahm_pkg::STATUS_OK;
        w_vout       = r_hit ? r_hit_val : '0;

        if (i_cfg_valid) begin
            n_lg = w_cfg_lg;
        end

        unique case (r_state)
            S_CLR: begin
                // clearing pass over the whole mark memory
                w_mark_we = 1'b1;
                n_clr_idx = r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_cmd        = i_s_axis_tuser;
                    n_key        = i_s_axis_tdata[KS-1:0];
                    n_hash       = i_s_axis_tdata[2*WW-1:WW];
                    n_val        = i_s_axis_tdata[3*WW-1:2*WW];
                    n_idx        = i_s_axis_tdata[WW+AW-1:WW] & w_mask;
                    n_perturb    = i_s_axis_tdata[2*WW-1:WW];
                    n_n          = '0;
                    n_hit        = 1'b0;
                    n_have_empty = 1'b0;
                    n_have_tomb  = 1'b0;
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                // read address is r_idx, word arrives next cycle
                n_state = S_EV;
            end
            S_EV: begin
                if (w_mark_q == oahm_pkg::MARK_EMPTY) begin
                    n_have_empty = 1'b1;
                    n_state      = S_FIN;
                end else if (w_mark_q == oahm_pkg::MARK_LIVE && w_key_eq && w_hash_eq) begin
                    n_hit     = 1'b1;
                    n_hit_val = w_data_q[DW-1:KS+WW];
                    n_state   = S_FIN;
                end else begin
                    // remember the first tombstone passed
                    if (w_mark_q != oahm_pkg::MARK_LIVE && !r_have_tomb) begin
                        n_have_tomb = 1'b1;
                        n_tomb_idx  = r_idx;
                    end
                    if (r_n == w_limit_m1) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx     = w_step_idx;
                        n_perturb = r_perturb >> PROBE_SHIFT;
                        n_n       = r_n + CW'(1);
                        n_state   = S_RD;
                    end
                end
            end
            S_FIN: begin
                unique case (r_cmd)
                    oahm_pkg::CMD_SET: begin
                        if (r_hit) begin
                            w_data_we = w_fin_go;
                        end else if (r_have_tomb) begin
                            w_data_we    = w_fin_go;
                            w_data_waddr = r_tomb_idx;
                            w_mark_we    = w_fin_go;
                            w_mark_waddr = r_tomb_idx;
                            w_mark_wdata = oahm_pkg::MARK_LIVE;
                            n_live       = r_live + CNT_W'(1);
                        end else if (r_have_empty && w_room) begin
                            w_data_we    = w_fin_go;
                            w_mark_we    = w_fin_go;
                            w_mark_waddr = r_idx;
                            w_mark_wdata = oahm_pkg::MARK_LIVE;
                            n_live       = r_live + CNT_W'(1);
                            n_fill       = r_fill + CNT_W'(1);
                        end else begin
                            w_status = oahm_pkg::STATUS_FULL;
                        end
                    end
                    oahm_pkg::CMD_DELETE: begin
                        if (r_hit) begin
                            w_mark_we    = w_fin_go;
                            w_mark_waddr = r_idx;
                            w_mark_wdata = oahm_pkg::MARK_TOMB;
                            n_live       = r_live - CNT_W'(1);
                        end else begin
                            w_status = oahm_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    default: begin
                        // lookup, and the unused code acts as one
                        if (!r_hit) begin
                            w_status = oahm_pkg::STATUS_NOT_FOUND;
                        end
                    end
                endcase
                if (w_fin_go) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, (w_fill3_next >= w_slots2),
                                   w_used_ext[oahm_pkg::USED_W-1:0], w_status, w_vout,
                                   r_hit};
                    n_state     = S_IDLE;
                end else begin
                    // hold counts until the result can be posted
                    n_live = r_live;
                    n_fill = r_fill;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // used count shown in its low bits
    assign w_used_ext = {{oahm_pkg::USED_W{1'b0}}, n_live};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_idx   <= '0;
            r_lg        <= LGW'(LG_RST);
            r_live      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_lg        <= n_lg;
            r_live      <= n_live;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_hash       <= n_hash;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_perturb    <= n_perturb;
        r_n          <= n_n;
        r_hit        <= n_hit;
        r_have_empty <= n_have_empty;
        r_have_tomb  <= n_have_tomb;
        r_tomb_idx   <= n_tomb_idx;
        r_hit_val    <= n_hit_val;
        r_out_data   <= n_out_data;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // live entries never outnumber live plus tombstone slots
    `OAHM_ASSERT_ALWAYS(a_live_le_fill, i_clk, i_rst_n, r_live <= r_fill,
        "live count exceeds fill count")

    // the probe counter stays within the probe limit
    `OAHM_ASSERT_ALWAYS(a_probe_limit, i_clk, i_rst_n, (r_state != S_EV) || (r_n <= w_limit_m1),
        "probe count ran past the limit")

    // a finished request always leaves a result in the output register
    `OAHM_ASSERT_NEXT(a_fin_posts, i_clk, i_rst_n, w_fin_go,
        o_m_axis_tvalid && (r_state == S_IDLE), "finished request left no result")

endmodule

// ===== rtl/oahm_ram.sv =====
// ----------------------------------------------------------------------------
// oahm_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module oahm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
